/* hdl/msa_pkg.sv */
// Shared types and constants for the MSA track run-length decoder.
`timescale 1ns / 1ps

package msa_pkg;

   // Field widths fixed by the request and result formats.
   localparam int LENGTH_WIDTH   = 16;
   localparam int BYTE_WIDTH     = 8;
   localparam int RUN_WIDTH      = 14;
   localparam int SPT_WIDTH      = 5;

   // Default sector size in bytes.
   localparam int SECTOR_BYTES_DEFAULT = 512;

   // Configuration port layout.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_SECTOR_COUNT = 1'b0;
   localparam logic [SPT_WIDTH-1:0] SPT_RESET = SPT_WIDTH'(9);

   // Request commands.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // Run-length marker byte.
   localparam logic [BYTE_WIDTH-1:0] RLE_MARK = 8'hE5;

   // Decoder position inside a marker, value, count high, count low sequence.
   localparam logic [1:0] PH_LIT    = 2'd0;
   localparam logic [1:0] PH_VALUE  = 2'd1;
   localparam logic [1:0] PH_CNT_HI = 2'd2;
   localparam logic [1:0] PH_CNT_LO = 2'd3;

   typedef struct packed {
      logic                    command;
      logic [LENGTH_WIDTH-1:0] track_length;
      logic [BYTE_WIDTH-1:0]   data_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] run_value;
      logic [RUN_WIDTH-1:0]  run_length;
      logic                  track_end;
      logic                  length_rejected;
   } rsp_type;

endpackage

/* hdl/msa_csr.sv */
// APB-style configuration register holding the sector count of a track.
`timescale 1ns / 1ps

module msa_csr
   import msa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [SPT_WIDTH-1:0]      sector_count
);

   logic [SPT_WIDTH-1:0] spt_ff;
   logic [SPT_WIDTH-1:0] spt_in;
   logic                 sel_spt;

   // Register i sits at byte address 4*i; only bit 2 selects a register.
   assign sel_spt = (paddr[2] == CSR_IDX_SECTOR_COUNT);
   assign pready  = 1'b1;

   always_comb begin
      spt_in = spt_ff;
      if (psel && penable && pwrite && sel_spt) begin
         spt_in = pwdata[SPT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff <= SPT_RESET;
      end else begin
         spt_ff <= spt_in;
      end
   end

   assign prdata = sel_spt ? CSR_DATA_WIDTH'(spt_ff) : '0;
   assign sector_count = spt_ff;

endmodule

/* hdl/msa_core.sv */
// Track decode state and run token generation for one accepted request.
`timescale 1ns / 1ps

module msa_core
   import msa_pkg::*;
#(
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SPT_WIDTH-1:0] sector_count,
   input  logic                 fire,
   input  req_type              req,
   output logic                 res_valid,
   output rsp_type              res
);

   logic [LENGTH_WIDTH-1:0] input_left_ff, input_left_in;
   logic [RUN_WIDTH-1:0]    output_left_ff, output_left_in;
   logic                    raw_copy_ff, raw_copy_in;
   logic [1:0]              phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0]   held_value_ff, held_value_in;
   logic [BYTE_WIDTH-1:0]   count_high_ff, count_high_in;
   logic                    track_open_ff, track_open_in;

   logic [RUN_WIDTH-1:0]    trk_bytes;
   logic [LENGTH_WIDTH-1:0] trk_bytes_ext;
   logic [LENGTH_WIDTH-1:0] twice_size;
   logic [LENGTH_WIDTH-1:0] input_left_dec;
   logic                    do_emit;
   logic [BYTE_WIDTH-1:0]   emit_value;
   logic [LENGTH_WIDTH-1:0] emit_count;
   logic [RUN_WIDTH-1:0]    run;
   logic [RUN_WIDTH-1:0]    output_left_after;
   logic                    emit_end;

   // The track size always fits the run width for the supported sector sizes.
   assign trk_bytes      = RUN_WIDTH'(sector_count * SECTOR_BYTES);
   assign trk_bytes_ext  = LENGTH_WIDTH'(trk_bytes);
   assign twice_size     = LENGTH_WIDTH'({trk_bytes, 1'b0});
   assign input_left_dec = input_left_ff - LENGTH_WIDTH'(1);

   always_comb begin
      input_left_in     = input_left_ff;
      output_left_in    = output_left_ff;
      raw_copy_in       = raw_copy_ff;
      phase_in          = phase_ff;
      held_value_in     = held_value_ff;
      count_high_in     = count_high_ff;
      track_open_in     = track_open_ff;
      res_valid         = 1'b0;
      res               = '0;
      do_emit           = 1'b0;
      emit_value        = '0;
      emit_count        = '0;
      run               = '0;
      output_left_after = output_left_ff;
      emit_end          = 1'b0;

      if (fire) begin
         if (req.command == CMD_START) begin
            track_open_in = 1'b0;
            phase_in      = PH_LIT;
            held_value_in = '0;
            count_high_in = '0;
            if (req.track_length > twice_size) begin
               input_left_in       = '0;
               output_left_in      = '0;
               raw_copy_in         = 1'b0;
               res_valid           = 1'b1;
               res.track_end       = 1'b1;
               res.length_rejected = 1'b1;
            end else begin
               input_left_in  = req.track_length;
               output_left_in = trk_bytes;
               raw_copy_in    = (req.track_length == trk_bytes_ext);
               track_open_in  = (req.track_length != '0) && (trk_bytes != '0);
            end
         end else if (track_open_ff) begin
            input_left_in = input_left_dec;
            if (raw_copy_ff) begin
               do_emit    = 1'b1;
               emit_value = req.data_byte;
               emit_count = LENGTH_WIDTH'(1);
            end else begin
               unique case (phase_ff)
                  PH_VALUE: begin
                     held_value_in = req.data_byte;
                     phase_in      = PH_CNT_HI;
                  end
                  PH_CNT_HI: begin
                     count_high_in = req.data_byte;
                     phase_in      = PH_CNT_LO;
                  end
                  PH_CNT_LO: begin
                     phase_in   = PH_LIT;
                     do_emit    = 1'b1;
                     emit_value = held_value_ff;
                     emit_count = {count_high_ff, req.data_byte};
                  end
                  PH_LIT: begin
                     // A marker only opens a run when value and count still follow.
                     if ((req.data_byte == RLE_MARK) &&
                         (input_left_dec >= LENGTH_WIDTH'(3))) begin
                        phase_in = PH_VALUE;
                     end else begin
                        do_emit    = 1'b1;
                        emit_value = req.data_byte;
                        emit_count = LENGTH_WIDTH'(1);
                     end
                  end
               endcase
            end

            if (do_emit) begin
               // Clip the run to the room left in the track.
               run = (emit_count < LENGTH_WIDTH'(output_left_ff)) ?
                     emit_count[RUN_WIDTH-1:0] : output_left_ff;
               output_left_after = output_left_ff - run;
               emit_end = (input_left_dec == '0) || (output_left_after == '0);
               output_left_in = output_left_after;
               if (emit_end) begin
                  track_open_in = 1'b0;
               end
               if (run != '0) begin
                  res_valid      = 1'b1;
                  res.run_value  = emit_value;
                  res.run_length = run;
                  res.track_end  = emit_end;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_left_ff  <= '0;
         output_left_ff <= '0;
         raw_copy_ff    <= 1'b0;
         phase_ff       <= PH_LIT;
         held_value_ff  <= '0;
         count_high_ff  <= '0;
         track_open_ff  <= 1'b0;
      end else begin
         input_left_ff  <= input_left_in;
         output_left_ff <= output_left_in;
         raw_copy_ff    <= raw_copy_in;
         phase_ff       <= phase_in;
         held_value_ff  <= held_value_in;
         count_high_ff  <= count_high_in;
         track_open_ff  <= track_open_in;
      end
   end

endmodule

/* hdl/msa_out_reg.sv */
// Result register that holds one run token until the consumer takes it.
`timescale 1ns / 1ps

module msa_out_reg
   import msa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    slot_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // The slot can take a new token in the same cycle the old one leaves.
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (slot_free) begin
         valid_in = load;
      end
      if (load) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* hdl/msa_track_rle_decoder.sv */
// Top level of the MSA track run-length decoder.
`timescale 1ns / 1ps

// The decoder turns one compressed MSA track into run tokens. A start request
// carries the compressed length of the track; a length above twice the track
// size (sector_count times SECTOR_BYTES) returns one token flagged
// length_rejected and closes the track, a length equal to the track size
// copies every byte as a literal, and any other length decodes 0xE5 followed
// by a value and a big-endian 16-bit count as one run, while any other byte
// is a literal. Run lengths are clipped to the bytes still free in the track,
// and track_end marks the token that uses the last compressed byte or fills the
// track. Runs that clip to zero and bytes after the track closes produce no
// token. One request is accepted every cycle; its token, if any, appears in the
// result register on the next cycle. The only limit on throughput is that
// single result register: a request is taken while the register is empty or
// while its token is being taken in the same cycle. The user must write the
// sector count register only while the decoder is idle; nothing enforces it.

module msa_track_rle_decoder
   import msa_pkg::*;
#(
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,

   // Request channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,

   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,

   // Configuration port.
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [SPT_WIDTH-1:0] sector_count;
   logic                 slot_free;
   logic                 fire;
   logic                 res_valid;
   rsp_type              res;

   // A request is taken whenever the result register has room for its token.
   assign req_ready = slot_free;
   assign fire      = req_valid && req_ready;

   msa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .sector_count (sector_count)
   );

   msa_core #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .sector_count (sector_count),
      .fire         (fire),
      .req          (req_data),
      .res_valid    (res_valid),
      .res          (res)
   );

   msa_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
